>>> design/cpt_pkg.sv
`default_nettype none

package cpt_pkg;

    // barycentric weights and edge parameters: unsigned Q1.30
    localparam int WGT_W     = 31;
    localparam int Q30_SHIFT = 30;
    localparam logic [WGT_W-1:0] Q30_ONE = {1'b1, {Q30_SHIFT{1'b0}}};

    // digit width of the staged wide multiplier
    localparam int DIG_W  = 16;

    localparam int DIST_W = 63;

    // how an edge parameter is formed
    typedef enum logic [1:0] {
        TSEL_ZERO,
        TSEL_ONE,
        TSEL_DIV
    } t_tsel;

    // which candidate point wins
    typedef enum logic [1:0] {
        CAND_PLANE,
        CAND_AB,
        CAND_BC,
        CAND_CA
    } t_cand;

endpackage

`default_nettype wire

>>> design/closest_point_on_triangle_top.sv
`default_nettype none

// Closest point on a 3D triangle. One beat per cycle in, one result beat out per
// input beat, in order. Each beat passes through the digit-staged determinant
// multipliers (68x68 at COORD_WIDTH 32) and the 31-stage restoring dividers that
// form the barycentric weights. Every stage holds a valid bit, so a stall on the
// output only holds back the input once all bubbles are filled. Coordinates are
// signed with COORD_WIDTH bits; weights are Q1.30; the squared distance
// saturates at its field maximum.
module closest_point_on_triangle_top #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic signed [COORD_WIDTH-1:0]   i_point_x,
    input  wire logic signed [COORD_WIDTH-1:0]   i_point_y,
    input  wire logic signed [COORD_WIDTH-1:0]   i_point_z,
    input  wire logic signed [COORD_WIDTH-1:0]   i_corner_a_x,
    input  wire logic signed [COORD_WIDTH-1:0]   i_corner_a_y,
    input  wire logic signed [COORD_WIDTH-1:0]   i_corner_a_z,
    input  wire logic signed [COORD_WIDTH-1:0]   i_corner_b_x,
    input  wire logic signed [COORD_WIDTH-1:0]   i_corner_b_y,
    input  wire logic signed [COORD_WIDTH-1:0]   i_corner_b_z,
    input  wire logic signed [COORD_WIDTH-1:0]   i_corner_c_x,
    input  wire logic signed [COORD_WIDTH-1:0]   i_corner_c_y,
    input  wire logic signed [COORD_WIDTH-1:0]   i_corner_c_z,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic signed [COORD_WIDTH-1:0]        o_near_x,
    output logic signed [COORD_WIDTH-1:0]        o_near_y,
    output logic signed [COORD_WIDTH-1:0]        o_near_z,
    output logic [cpt_pkg::WGT_W-1:0]            o_weight_a,
    output logic [cpt_pkg::WGT_W-1:0]            o_weight_b,
    output logic [cpt_pkg::WGT_W-1:0]            o_weight_c,
    output logic [cpt_pkg::DIST_W-1:0]           o_distance_squared
);

    localparam int W     = COORD_WIDTH;
    localparam int DW    = W + 1;
    localparam int PW2   = 2 * DW;
    localparam int DOTW  = PW2 + 2;
    localparam int NW    = 2 * DOTW;
    localparam int NW1   = NW + 1;
    localparam int NS_W  = NW + 2;
    localparam int QW    = cpt_pkg::WGT_W;
    localparam int QS    = cpt_pkg::Q30_SHIFT;
    localparam int PM_W  = W + QW + 1;
    localparam int PS_W  = PM_W + 2;
    localparam int EM_W  = DW + QW + 1;
    localparam int TS_W  = $bits(cpt_pkg::t_tsel);
    localparam int MUL_N = (DOTW + cpt_pkg::DIG_W - 1) / cpt_pkg::DIG_W;

    localparam logic [QW-1:0] ONE = cpt_pkg::Q30_ONE;

    // stage map
    localparam int S_IN   = 0;
    localparam int S_DIF  = 1;
    localparam int S_PRD  = 2;
    localparam int S_DOT  = 3;
    localparam int S_ED   = S_DOT + 1;
    localparam int S_MUL  = S_DOT + MUL_N;
    localparam int S_DET  = S_MUL + 1;
    localparam int S_SUM  = S_DET + 1;
    localparam int S_INS  = S_SUM + 1;
    localparam int S_EDV  = S_DOT + QW;
    localparam int S_PDV  = S_DET + QW;
    localparam int S_WGT  = S_PDV + 1;
    localparam int S_MPY  = S_WGT + 1;
    localparam int S_POS  = S_MPY + 1;
    localparam int S_DIF2 = S_POS + 1;
    localparam int S_SQ   = S_DIF2 + 1;
    localparam int S_DST  = S_SQ + 1;
    localparam int S_CMP  = S_DST + 1;
    localparam int S_OUT  = S_CMP + 1;
    localparam int L      = S_OUT + 1;

    // difference vectors
    localparam int V_E1 = 0;  // b - a
    localparam int V_E2 = 1;  // c - a
    localparam int V_R  = 2;  // p - a
    localparam int V_BC = 3;  // c - b
    localparam int V_RB = 4;  // p - b
    localparam int V_CA = 5;  // a - c
    localparam int V_RC = 6;  // p - c
    // points: 0 p, 1 a, 2 b, 3 c
    localparam int DIF_M [7] = '{2, 3, 0, 3, 0, 1, 0};
    localparam int DIF_S [7] = '{1, 1, 1, 2, 2, 3, 3};

    // dot products
    localparam int D00 = 0;
    localparam int D01 = 1;
    localparam int D11 = 2;
    localparam int D20 = 3;
    localparam int D21 = 4;
    localparam int EBC = 5;
    localparam int NBC = 6;
    localparam int NCA = 7;
    localparam int DOT_L [8] = '{V_E1, V_E1, V_E2, V_R, V_R, V_BC, V_RB, V_RC};
    localparam int DOT_R [8] = '{V_E1, V_E2, V_E2, V_E1, V_E2, V_BC, V_BC, V_CA};

    // edges AB, BC, CA
    localparam int EXT_I [3] = '{D00, EBC, D11};
    localparam int NUM_I [3] = '{D20, NBC, NCA};
    localparam int DIR_I [3] = '{V_E1, V_BC, V_CA};

    // determinant terms: D = m0 - m1, Nb = m2 - m3, Nc = m4 - m5
    localparam int MUL_A [6] = '{D00, D01, D11, D01, D00, D01};
    localparam int MUL_B [6] = '{D11, D01, D20, D21, D21, D20};

    // ------------------------------------------------------------ flow control
    logic [L-1:0] r_v;
    logic [L-1:0] en;

    always_comb begin
        en[L-1] = !r_v[L-1] || !i_stall;
        for (int j = L - 2; j >= 0; j--) begin
            en[j] = !r_v[j] || en[j+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int j = 1; j < L; j++) begin
                if (en[j]) begin
                    r_v[j] <= r_v[j-1];
                end
            end
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_v[L-1];

    // ------------------------------------------------------------ input beat
    logic signed [W-1:0] r_p [3];
    logic signed [W-1:0] r_k [3][3];   // corner, axis

    always_ff @(posedge i_clk) begin
        if (en[S_IN]) begin
            r_p[0]    <= i_point_x;
            r_p[1]    <= i_point_y;
            r_p[2]    <= i_point_z;
            r_k[0][0] <= i_corner_a_x;
            r_k[0][1] <= i_corner_a_y;
            r_k[0][2] <= i_corner_a_z;
            r_k[1][0] <= i_corner_b_x;
            r_k[1][1] <= i_corner_b_y;
            r_k[1][2] <= i_corner_b_z;
            r_k[2][0] <= i_corner_c_x;
            r_k[2][1] <= i_corner_c_y;
            r_k[2][2] <= i_corner_c_z;
        end
    end

    logic signed [W-1:0] pts [4][3];

    always_comb begin
        for (int ax = 0; ax < 3; ax++) begin
            pts[0][ax] = r_p[ax];
            for (int c = 0; c < 3; c++) begin
                pts[c+1][ax] = r_k[c][ax];
            end
        end
    end

    // ------------------------------------------------------------ differences
    logic signed [DW-1:0] r_dif [7][3];

    always_ff @(posedge i_clk) begin
        if (en[S_DIF]) begin
            for (int v = 0; v < 7; v++) begin
                for (int ax = 0; ax < 3; ax++) begin
                    r_dif[v][ax] <= DW'(pts[DIF_M[v]][ax]) - DW'(pts[DIF_S[v]][ax]);
                end
            end
        end
    end

    // ------------------------------------------------------------ dot products
    logic signed [PW2-1:0]  r_prd [8][3];
    logic signed [DOTW-1:0] r_dot [8];

    always_ff @(posedge i_clk) begin
        if (en[S_PRD]) begin
            for (int d = 0; d < 8; d++) begin
                for (int ax = 0; ax < 3; ax++) begin
                    r_prd[d][ax] <= r_dif[DOT_L[d]][ax] * r_dif[DOT_R[d]][ax];
                end
            end
        end
        if (en[S_DOT]) begin
            for (int d = 0; d < 8; d++) begin
                r_dot[d] <= DOTW'(r_prd[d][0]) + DOTW'(r_prd[d][1]) + DOTW'(r_prd[d][2]);
            end
        end
    end

    // ------------------------------------------------------------ edge parameters
    cpt_pkg::t_tsel r_tsel [3];
    cpt_pkg::t_tsel n_tsel [3];

    // numerator negative or zero, or a zero-length edge, clamps to the start corner
    always_comb begin
        for (int e = 0; e < 3; e++) begin
            priority if (r_dot[EXT_I[e]] == '0 || r_dot[NUM_I[e]][DOTW-1]
                         || r_dot[NUM_I[e]] == '0) begin
                n_tsel[e] = cpt_pkg::TSEL_ZERO;
            end else if (r_dot[NUM_I[e]] >= r_dot[EXT_I[e]]) begin
                n_tsel[e] = cpt_pkg::TSEL_ONE;
            end else begin
                n_tsel[e] = cpt_pkg::TSEL_DIV;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[S_ED]) begin
            r_tsel <= n_tsel;
        end
    end

    logic [QW-1:0]     edge_q [3];
    logic [3*QW-1:0]   edge_q_pk;
    logic [3*QW-1:0]   edge_q_d;
    logic [3*TS_W-1:0] tsel_pk;
    logic [3*TS_W-1:0] tsel_d;

    for (genvar e = 0; e < 3; e++) begin : g_ediv
        cpt_div #(.N_W(DOTW)) u_div (
            .i_clk (i_clk),
            .i_en  (en[S_EDV:S_DOT+1]),
            .i_num (r_dot[NUM_I[e]]),
            .i_den (r_dot[EXT_I[e]]),
            .o_q   (edge_q[e])
        );
        assign edge_q_pk[e*QW +: QW]     = edge_q[e];
        assign tsel_pk[e*TS_W +: TS_W]   = r_tsel[e];
    end

    cpt_dly #(.WIDTH(3*QW), .DEPTH(S_PDV-S_EDV)) u_dly_eq (
        .i_clk (i_clk), .i_en (en[S_PDV:S_EDV+1]), .i_d (edge_q_pk), .o_q (edge_q_d)
    );

    cpt_dly #(.WIDTH(3*TS_W), .DEPTH(S_PDV-S_ED)) u_dly_ts (
        .i_clk (i_clk), .i_en (en[S_PDV:S_ED+1]), .i_d (tsel_pk), .o_q (tsel_d)
    );

    // ------------------------------------------------------------ plane solve
    logic signed [2*DOTW-1:0] mprod [6];

    for (genvar m = 0; m < 6; m++) begin : g_mul
        cpt_mul #(.A_W(DOTW), .B_W(DOTW)) u_mul (
            .i_clk (i_clk),
            .i_en  (en[S_MUL:S_DOT+1]),
            .i_a   (r_dot[MUL_A[m]]),
            .i_b   (r_dot[MUL_B[m]]),
            .o_p   (mprod[m])
        );
    end

    logic signed [NW1-1:0]  r_det;
    logic signed [NW1-1:0]  r_nb;
    logic signed [NW1-1:0]  r_nc;
    logic signed [NS_W-1:0] r_sum;
    logic signed [NW1-1:0]  r_det2;
    logic                   r_nbn;
    logic                   r_ncn;
    logic                   r_dnz;
    logic                   r_in;

    always_ff @(posedge i_clk) begin
        if (en[S_DET]) begin
            r_det <= NW1'(mprod[0]) - NW1'(mprod[1]);
            r_nb  <= NW1'(mprod[2]) - NW1'(mprod[3]);
            r_nc  <= NW1'(mprod[4]) - NW1'(mprod[5]);
        end
        if (en[S_SUM]) begin
            r_sum  <= NS_W'(r_nb) + NS_W'(r_nc);
            r_det2 <= r_det;
            r_nbn  <= r_nb[NW];
            r_ncn  <= r_nc[NW];
            r_dnz  <= r_det != '0;
        end
        if (en[S_INS]) begin
            r_in <= r_dnz && !r_nbn && !r_ncn && (r_sum <= NS_W'(r_det2));
        end
    end

    logic [QW-1:0] wb_q;
    logic [QW-1:0] wc_q;

    cpt_div #(.N_W(NW)) u_div_b (
        .i_clk (i_clk), .i_en (en[S_PDV:S_DET+1]),
        .i_num (r_nb[NW-1:0]), .i_den (r_det[NW-1:0]), .o_q (wb_q)
    );

    cpt_div #(.N_W(NW)) u_div_c (
        .i_clk (i_clk), .i_en (en[S_PDV:S_DET+1]),
        .i_num (r_nc[NW-1:0]), .i_den (r_det[NW-1:0]), .o_q (wc_q)
    );

    logic in_d;

    cpt_dly #(.WIDTH(1), .DEPTH(S_DST-S_INS)) u_dly_in (
        .i_clk (i_clk), .i_en (en[S_DST:S_INS+1]), .i_d (r_in), .o_q (in_d)
    );

    // ------------------------------------------------------------ side channels
    logic [9*W-1:0]  abc_pk;
    logic [9*W-1:0]  abc_w;
    logic [9*W-1:0]  abc_m;
    logic [3*W-1:0]  p_pk;
    logic [3*W-1:0]  p_d;
    logic [9*DW-1:0] dir_pk;
    logic [9*DW-1:0] dir_d;

    always_comb begin
        for (int ax = 0; ax < 3; ax++) begin
            p_pk[ax*W +: W] = r_p[ax];
            for (int c = 0; c < 3; c++) begin
                abc_pk[(c*3+ax)*W +: W] = r_k[c][ax];
            end
            for (int e = 0; e < 3; e++) begin
                dir_pk[(e*3+ax)*DW +: DW] = r_dif[DIR_I[e]][ax];
            end
        end
    end

    cpt_dly #(.WIDTH(9*W), .DEPTH(S_WGT-S_IN)) u_dly_abc (
        .i_clk (i_clk), .i_en (en[S_WGT:S_IN+1]), .i_d (abc_pk), .o_q (abc_w)
    );

    cpt_dly #(.WIDTH(9*W), .DEPTH(S_MPY-S_WGT)) u_dly_abc2 (
        .i_clk (i_clk), .i_en (en[S_MPY:S_WGT+1]), .i_d (abc_w), .o_q (abc_m)
    );

    cpt_dly #(.WIDTH(3*W), .DEPTH(S_POS-S_IN)) u_dly_p (
        .i_clk (i_clk), .i_en (en[S_POS:S_IN+1]), .i_d (p_pk), .o_q (p_d)
    );

    cpt_dly #(.WIDTH(9*DW), .DEPTH(S_WGT-S_DIF)) u_dly_dir (
        .i_clk (i_clk), .i_en (en[S_WGT:S_DIF+1]), .i_d (dir_pk), .o_q (dir_d)
    );

    // ------------------------------------------------------------ weights
    logic [QW-1:0] r_wgt [3];   // plane wa, wb, wc
    logic [QW-1:0] r_t   [3];   // edge parameter per edge
    logic [QW-1:0] n_t   [3];

    always_comb begin
        for (int e = 0; e < 3; e++) begin
            unique case (cpt_pkg::t_tsel'(tsel_d[e*TS_W +: TS_W]))
                cpt_pkg::TSEL_ZERO: n_t[e] = '0;
                cpt_pkg::TSEL_ONE:  n_t[e] = ONE;
                cpt_pkg::TSEL_DIV:  n_t[e] = edge_q_d[e*QW +: QW];
                default:            n_t[e] = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[S_WGT]) begin
            r_wgt[0] <= ONE - wb_q - wc_q;
            r_wgt[1] <= wb_q;
            r_wgt[2] <= wc_q;
            r_t      <= n_t;
        end
    end

    // ------------------------------------------------------------ candidate points
    logic signed [PM_W-1:0] r_pm [3][3];   // axis, corner
    logic signed [EM_W-1:0] r_em [3][3];   // edge, axis

    always_ff @(posedge i_clk) begin
        if (en[S_MPY]) begin
            for (int ax = 0; ax < 3; ax++) begin
                for (int c = 0; c < 3; c++) begin
                    r_pm[ax][c] <= $signed(abc_w[(c*3+ax)*W +: W]) * $signed({1'b0, r_wgt[c]});
                end
                for (int e = 0; e < 3; e++) begin
                    r_em[e][ax] <= $signed(dir_d[(e*3+ax)*DW +: DW]) * $signed({1'b0, r_t[e]});
                end
            end
        end
    end

    // candidate 0 is the plane point, 1..3 the edges AB, BC, CA
    logic signed [W-1:0] r_pos [4][3];
    logic signed [W-1:0] n_pos [4][3];

    always_comb begin
        logic signed [PS_W-1:0] psum;
        logic signed [EM_W-1:0] eofs;
        logic signed [DW-1:0]   ept;
        for (int ax = 0; ax < 3; ax++) begin
            // round half up: add half, floor by part-select
            psum = PS_W'(r_pm[ax][0]) + PS_W'(r_pm[ax][1]) + PS_W'(r_pm[ax][2])
                 + (PS_W'(1) <<< (QS - 1));
            n_pos[0][ax] = psum[QS +: W];
            for (int e = 0; e < 3; e++) begin
                eofs = r_em[e][ax] + (EM_W'(1) <<< (QS - 1));
                ept  = DW'($signed(abc_m[(e*3+ax)*W +: W])) + eofs[QS +: DW];
                n_pos[e+1][ax] = ept[W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[S_POS]) begin
            r_pos <= n_pos;
        end
    end

    // ------------------------------------------------------------ distances
    logic signed [DW-1:0]  r_d2  [4][3];
    logic signed [PW2-1:0] r_sq  [4][3];
    logic        [DOTW-1:0] r_dst [4];

    always_ff @(posedge i_clk) begin
        if (en[S_DIF2]) begin
            for (int k = 0; k < 4; k++) begin
                for (int ax = 0; ax < 3; ax++) begin
                    r_d2[k][ax] <= DW'($signed(p_d[ax*W +: W])) - DW'(r_pos[k][ax]);
                end
            end
        end
        if (en[S_SQ]) begin
            for (int k = 0; k < 4; k++) begin
                for (int ax = 0; ax < 3; ax++) begin
                    r_sq[k][ax] <= r_d2[k][ax] * r_d2[k][ax];
                end
            end
        end
        if (en[S_DST]) begin
            for (int k = 0; k < 4; k++) begin
                r_dst[k] <= DOTW'(r_sq[k][0]) + DOTW'(r_sq[k][1]) + DOTW'(r_sq[k][2]);
            end
        end
    end

    // ------------------------------------------------------------ pick
    cpt_pkg::t_cand r_pick;
    cpt_pkg::t_cand n_pick;

    // earlier edge wins ties
    always_comb begin
        priority if (in_d) begin
            n_pick = cpt_pkg::CAND_PLANE;
        end else if (r_dst[2] < r_dst[1]) begin
            n_pick = (r_dst[3] < r_dst[2]) ? cpt_pkg::CAND_CA : cpt_pkg::CAND_BC;
        end else begin
            n_pick = (r_dst[3] < r_dst[1]) ? cpt_pkg::CAND_CA : cpt_pkg::CAND_AB;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[S_CMP]) begin
            r_pick <= n_pick;
        end
    end

    logic [4*DOTW-1:0] dst_pk;
    logic [4*DOTW-1:0] dst_c;
    logic [12*W-1:0]   pos_pk;
    logic [12*W-1:0]   pos_c;
    logic [6*QW-1:0]   wgt_pk;
    logic [6*QW-1:0]   wgt_c;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            dst_pk[k*DOTW +: DOTW] = r_dst[k];
            for (int ax = 0; ax < 3; ax++) begin
                pos_pk[(k*3+ax)*W +: W] = r_pos[k][ax];
            end
        end
        for (int i = 0; i < 3; i++) begin
            wgt_pk[i*QW +: QW]     = r_wgt[i];
            wgt_pk[(i+3)*QW +: QW] = r_t[i];
        end
    end

    cpt_dly #(.WIDTH(4*DOTW), .DEPTH(S_CMP-S_DST)) u_dly_dst (
        .i_clk (i_clk), .i_en (en[S_CMP:S_DST+1]), .i_d (dst_pk), .o_q (dst_c)
    );

    cpt_dly #(.WIDTH(12*W), .DEPTH(S_CMP-S_POS)) u_dly_pos (
        .i_clk (i_clk), .i_en (en[S_CMP:S_POS+1]), .i_d (pos_pk), .o_q (pos_c)
    );

    cpt_dly #(.WIDTH(6*QW), .DEPTH(S_CMP-S_WGT)) u_dly_wgt (
        .i_clk (i_clk), .i_en (en[S_CMP:S_WGT+1]), .i_d (wgt_pk), .o_q (wgt_c)
    );

    // ------------------------------------------------------------ output beat
    logic [1:0]      sel_k;
    logic [QW-1:0]   sel_w [3];
    logic [QW-1:0]   t_sel;
    logic [127:0]    dst_wide;
    logic [DOTW-1:0] dst_sel;

    always_comb begin
        t_sel = '0;
        unique case (r_pick)
            cpt_pkg::CAND_PLANE: begin
                sel_k    = 2'd0;
                sel_w[0] = wgt_c[0 +: QW];
                sel_w[1] = wgt_c[QW +: QW];
                sel_w[2] = wgt_c[2*QW +: QW];
            end
            cpt_pkg::CAND_AB: begin
                sel_k    = 2'd1;
                t_sel    = wgt_c[3*QW +: QW];
                sel_w[0] = ONE - t_sel;
                sel_w[1] = t_sel;
                sel_w[2] = '0;
            end
            cpt_pkg::CAND_BC: begin
                sel_k    = 2'd2;
                t_sel    = wgt_c[4*QW +: QW];
                sel_w[0] = '0;
                sel_w[1] = ONE - t_sel;
                sel_w[2] = t_sel;
            end
            cpt_pkg::CAND_CA: begin
                sel_k    = 2'd3;
                t_sel    = wgt_c[5*QW +: QW];
                sel_w[0] = t_sel;
                sel_w[1] = '0;
                sel_w[2] = ONE - t_sel;
            end
        endcase
        dst_sel  = dst_c[sel_k*DOTW +: DOTW];
        dst_wide = 128'(dst_sel);
    end

    logic signed [W-1:0]           r_ox;
    logic signed [W-1:0]           r_oy;
    logic signed [W-1:0]           r_oz;
    logic [QW-1:0]                 r_owa;
    logic [QW-1:0]                 r_owb;
    logic [QW-1:0]                 r_owc;
    logic [cpt_pkg::DIST_W-1:0]    r_odst;

    always_ff @(posedge i_clk) begin
        if (en[S_OUT]) begin
            r_ox   <= pos_c[(sel_k*3+0)*W +: W];
            r_oy   <= pos_c[(sel_k*3+1)*W +: W];
            r_oz   <= pos_c[(sel_k*3+2)*W +: W];
            r_owa  <= sel_w[0];
            r_owb  <= sel_w[1];
            r_owc  <= sel_w[2];
            r_odst <= (|dst_wide[127:cpt_pkg::DIST_W]) ? '1
                                                       : dst_wide[cpt_pkg::DIST_W-1:0];
        end
    end

    assign o_near_x           = r_ox;
    assign o_near_y           = r_oy;
    assign o_near_z           = r_oz;
    assign o_weight_a         = r_owa;
    assign o_weight_b         = r_owb;
    assign o_weight_c         = r_owc;
    assign o_distance_squared = r_odst;

endmodule

`default_nettype wire

>>> design/cpt_dly.sv
`default_nettype none

module cpt_dly #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  wire logic             i_clk,
    input  wire logic [DEPTH-1:0] i_en,
    input  wire logic [WIDTH-1:0] i_d,
    output logic      [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_q [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_q[0] <= i_d;
        end
        for (int k = 1; k < DEPTH; k++) begin
            if (i_en[k]) begin
                r_q[k] <= r_q[k-1];
            end
        end
    end

    assign o_q = r_q[DEPTH-1];

endmodule

`default_nettype wire

>>> design/cpt_mul.sv
`default_nettype none

// Signed A x B, one 16-bit digit of B per stage, accumulating partial products.
module cpt_mul #(
    parameter int A_W = 68,
    parameter int B_W = 68,
    localparam int STG = (B_W + cpt_pkg::DIG_W - 1) / cpt_pkg::DIG_W
) (
    input  wire logic                      i_clk,
    input  wire logic [STG-1:0]            i_en,
    input  wire logic signed [A_W-1:0]     i_a,
    input  wire logic signed [B_W-1:0]     i_b,
    output logic      signed [A_W+B_W-1:0] o_p
);

    localparam int DW   = cpt_pkg::DIG_W;
    localparam int P_W  = A_W + B_W;
    localparam int BX_W = STG * DW;

    logic signed [P_W-1:0]  r_acc [STG];
    logic signed [A_W-1:0]  r_a   [STG];
    logic        [BX_W-1:0] r_b   [STG];

    for (genvar k = 0; k < STG; k++) begin : g_stg
        logic signed [A_W-1:0]  a_in;
        logic        [BX_W-1:0] b_in;
        logic signed [P_W-1:0]  acc_in;
        logic signed [DW:0]     dig;
        logic signed [A_W+DW:0] pp;

        if (k == 0) begin : g_first
            assign a_in   = i_a;
            assign b_in   = BX_W'(i_b);
            assign acc_in = '0;
        end else begin : g_next
            assign a_in   = r_a[k-1];
            assign b_in   = r_b[k-1];
            assign acc_in = r_acc[k-1];
        end

        // top digit carries the sign of B
        assign dig = (k == STG - 1) ? {b_in[k*DW+DW-1], b_in[k*DW +: DW]}
                                    : {1'b0, b_in[k*DW +: DW]};
        assign pp  = a_in * dig;

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_acc[k] <= acc_in + (P_W'(pp) <<< (k * DW));
                r_a[k]   <= a_in;
                r_b[k]   <= b_in;
            end
        end
    end

    assign o_p = r_acc[STG-1];

endmodule

`default_nettype wire

>>> design/cpt_div.sv
`default_nettype none

// floor(num * 2^30 / den) for 0 <= num <= den, one quotient bit per stage.
module cpt_div #(
    parameter int N_W = 136,
    localparam int STG = cpt_pkg::WGT_W
) (
    input  wire logic                     i_clk,
    input  wire logic [STG-1:0]           i_en,
    input  wire logic [N_W-1:0]           i_num,
    input  wire logic [N_W-1:0]           i_den,
    output logic [cpt_pkg::WGT_W-1:0]     o_q
);

    localparam int QW = cpt_pkg::WGT_W;

    logic [N_W:0]   r_rem [STG];
    logic [N_W-1:0] r_den [STG];
    logic [QW-1:0]  r_q   [STG];

    for (genvar k = 0; k < STG; k++) begin : g_stg
        logic [N_W:0]   rem_in;
        logic [N_W-1:0] den_in;
        logic [QW-1:0]  q_in;
        logic           ge;

        if (k == 0) begin : g_first
            assign rem_in = {1'b0, i_num};
            assign den_in = i_den;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = {r_rem[k-1][N_W-1:0], 1'b0};
            assign den_in = r_den[k-1];
            assign q_in   = r_q[k-1];
        end

        assign ge = rem_in >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_rem[k] <= ge ? rem_in - {1'b0, den_in} : rem_in;
                r_den[k] <= den_in;
                r_q[k]   <= {q_in[QW-2:0], ge};
            end
        end
    end

    assign o_q = r_q[STG-1];

endmodule

`default_nettype wire

>>> test/testbench.sv
`default_nettype none

module testbench;

    localparam int CW = 32;
    localparam int ONE = 32'sh0001_0000;
    localparam int CMAX = 32'sh7fff_ffff;
    localparam int CMIN = 32'sh8000_0000;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 80;

    typedef logic signed [199:0] t_wide;

    typedef struct {
        logic signed [CW-1:0]          near_x, near_y, near_z;
        logic [cpt_pkg::WGT_W-1:0]     wa, wb, wc;
        logic [cpt_pkg::DIST_W-1:0]    dsq;
    } t_near_pt;

    typedef struct {
        longint pos[3];
        logic [cpt_pkg::WGT_W-1:0] wgt[3];
        t_wide dsq;
    } t_cand_pt;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic signed [CW-1:0] i_point_x = '0, i_point_y = '0, i_point_z = '0;
    logic signed [CW-1:0] i_corner_a_x = '0, i_corner_a_y = '0, i_corner_a_z = '0;
    logic signed [CW-1:0] i_corner_b_x = '0, i_corner_b_y = '0, i_corner_b_z = '0;
    logic signed [CW-1:0] i_corner_c_x = '0, i_corner_c_y = '0, i_corner_c_z = '0;
    logic o_stall, o_valid;
    logic signed [CW-1:0] o_near_x, o_near_y, o_near_z;
    logic [cpt_pkg::WGT_W-1:0] o_weight_a, o_weight_b, o_weight_c;
    logic [cpt_pkg::DIST_W-1:0] o_distance_squared;

    closest_point_on_triangle_top #(.COORD_WIDTH(CW)) uut (.*);

    always #6 i_clk = ~i_clk;

    t_near_pt pending_near[$];
    int errors = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_cnt = 0;

    // ---------------- prediction ----------------
    function automatic t_wide dot3(longint x[3], longint y[3]);
        t_wide s;
        s = 0;
        for (int i = 0; i < 3; i++) s += t_wide'(x[i]) * t_wide'(y[i]);
        return s;
    endfunction

    // floor(num * 2^30 / den), 0 <= num <= den
    function automatic logic [cpt_pkg::WGT_W-1:0] q30_ratio(t_wide num, t_wide den);
        t_wide q;
        q = (num <<< cpt_pkg::Q30_SHIFT) / den;
        return q[cpt_pkg::WGT_W-1:0];
    endfunction

    function automatic longint round_q30(longint v);
        return (v + (64'sd1 <<< 29)) >>> cpt_pkg::Q30_SHIFT;
    endfunction

    function automatic t_cand_pt clamp_to_side(longint p[3], longint f[3], longint s[3],
                                               int fi, int si);
        t_cand_pt k;
        longint dir[3], rel[3], diff[3];
        t_wide span, num;
        logic [cpt_pkg::WGT_W-1:0] t;
        t = '0;
        for (int i = 0; i < 3; i++) begin
            dir[i] = s[i] - f[i];
            rel[i] = p[i] - f[i];
        end
        span = dot3(dir, dir);
        if (span != 0) begin
            num = dot3(rel, dir);
            if (num <= 0) t = '0;
            else if (num >= span) t = cpt_pkg::Q30_ONE;
            else t = q30_ratio(num, span);
        end
        for (int i = 0; i < 3; i++) begin
            k.pos[i] = f[i] + round_q30(dir[i] * longint'(t));
            k.wgt[i] = '0;
            diff[i] = p[i] - k.pos[i];
        end
        k.wgt[fi] = cpt_pkg::Q30_ONE - t;
        k.wgt[si] = t;
        k.dsq = dot3(diff, diff);
        return k;
    endfunction

    function automatic t_near_pt closest_on_tri(longint p[3], longint a[3], longint b[3],
                                                longint c[3]);
        longint e1[3], e2[3], r[3], diff[3];
        t_wide d00, d01, d11, d20, d21, det, nb, nc;
        t_cand_pt best, k;
        t_near_pt res;
        for (int i = 0; i < 3; i++) begin
            e1[i] = b[i] - a[i];
            e2[i] = c[i] - a[i];
            r[i] = p[i] - a[i];
        end
        d00 = dot3(e1, e1);
        d01 = dot3(e1, e2);
        d11 = dot3(e2, e2);
        d20 = dot3(r, e1);
        d21 = dot3(r, e2);
        det = d00 * d11 - d01 * d01;
        nb = d11 * d20 - d01 * d21;
        nc = d00 * d21 - d01 * d20;
        if (det != 0 && nb >= 0 && nc >= 0 && nb + nc <= det) begin
            best.wgt[1] = q30_ratio(nb, det);
            best.wgt[2] = q30_ratio(nc, det);
            best.wgt[0] = cpt_pkg::Q30_ONE - best.wgt[1] - best.wgt[2];
            for (int i = 0; i < 3; i++) begin
                best.pos[i] = round_q30(a[i] * longint'(best.wgt[0])
                                      + b[i] * longint'(best.wgt[1])
                                      + c[i] * longint'(best.wgt[2]));
                diff[i] = p[i] - best.pos[i];
            end
            best.dsq = dot3(diff, diff);
        end else begin
            // first edge keeps ties
            best = clamp_to_side(p, a, b, 0, 1);
            k = clamp_to_side(p, b, c, 1, 2);
            if (k.dsq < best.dsq) best = k;
            k = clamp_to_side(p, c, a, 2, 0);
            if (k.dsq < best.dsq) best = k;
        end
        res.near_x = best.pos[0][CW-1:0];
        res.near_y = best.pos[1][CW-1:0];
        res.near_z = best.pos[2][CW-1:0];
        res.wa = best.wgt[0];
        res.wb = best.wgt[1];
        res.wc = best.wgt[2];
        if (best.dsq >= (t_wide'(1) <<< cpt_pkg::DIST_W)) res.dsq = {cpt_pkg::DIST_W{1'b1}};
        else res.dsq = best.dsq[cpt_pkg::DIST_W-1:0];
        return res;
    endfunction

    // ---------------- stimulus ----------------
    task automatic send_query(input int px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz);
        longint p[3], a[3], b[3], c[3];
        p = '{px, py, pz};
        a = '{ax, ay, az};
        b = '{bx, by, bz};
        c = '{cx, cy, cz};
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                repeat ($urandom_range(1, 8)) begin
                    @(negedge i_clk);
                    i_valid <= 1'b0;
                end
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_point_x <= px; i_point_y <= py; i_point_z <= pz;
        i_corner_a_x <= ax; i_corner_a_y <= ay; i_corner_a_z <= az;
        i_corner_b_x <= bx; i_corner_b_y <= by; i_corner_b_z <= bz;
        i_corner_c_x <= cx; i_corner_c_y <= cy; i_corner_c_z <= cz;
        do @(posedge i_clk); while (o_stall);
        pending_near.insert(pending_near.size(), closest_on_tri(p, a, b, c));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_near.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        // projection inside, on a corner, on the border
        send_query(ONE, ONE, 5*ONE, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0);
        send_query(0, 0, 0, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0);
        send_query(2*ONE, 2*ONE, 0, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0);
        send_query(ONE/3, ONE/7, -ONE, 0, 0, 0, 3*ONE, ONE, 0, ONE, 5*ONE, 2*ONE);
        // outside each edge and past each corner
        send_query(2*ONE, -3*ONE, 0, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0);
        send_query(3*ONE, 3*ONE, 2*ONE, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0);
        send_query(-2*ONE, 2*ONE, 0, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0);
        send_query(6*ONE, -ONE, ONE, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0);
        send_query(-ONE, 7*ONE, 0, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0);
        send_query(-ONE, -ONE, -ONE, 0, 0, 0, 4*ONE, 0, 0, 0, 4*ONE, 0);
        // degenerate: single point, two equal corners, collinear corners
        send_query(ONE, 2*ONE, 3*ONE, 5, 5, 5, 5, 5, 5, 5, 5, 5);
        send_query(ONE, 2*ONE, 3*ONE, 0, 0, 0, 0, 0, 0, 3*ONE, 0, 0);
        send_query(ONE, ONE, 0, 0, 0, 0, ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE);
        send_query(5*ONE, 0, 0, 0, 0, 0, 2*ONE, 0, 0, -2*ONE, 0, 0);
        // equidistant from edges AB and CA
        send_query(-ONE, -ONE, 0, 0, 0, 0, 2*ONE, 0, 0, 0, 2*ONE, 0);
        // coordinate extremes, distance saturation
        send_query(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
        send_query(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
        send_query(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
        send_query(0, 0, 0, CMIN, CMIN, 0, CMAX, CMIN, 0, 0, CMAX, CMIN);
        send_query(CMIN, CMAX, 0, CMAX, 0, CMIN, 0, CMIN, CMAX, CMIN, CMAX, 0);
        send_query(-1, -1, -1, 0, 0, 0, 1, 0, 0, 0, 1, 0);
    endtask

    function automatic int rand_coord(int mode);
        case (mode)
            0: return int'($urandom());
            1: return int'($urandom_range(0, 2**21)) - 2**20;
            default: return int'($urandom_range(0, 2**9)) - 2**8;
        endcase
    endfunction

    task automatic test_random(input int count);
        int v[12];
        int mode;
        for (int n = 0; n < count; n++) begin
            mode = $urandom_range(0, 2);
            foreach (v[i]) v[i] = rand_coord(mode);
            case ($urandom_range(0, 9))
                0: for (int i = 0; i < 3; i++) v[6+i] = v[3+i];            // A == B
                1: for (int i = 0; i < 3; i++) v[9+i] = 2*v[6+i] - v[3+i]; // collinear
                2: for (int i = 0; i < 3; i++) v[i] = v[3+3*$urandom_range(0,2)+i];
                3: for (int i = 0; i < 3; i++) v[i] = (v[3+i] + v[6+i] + v[9+i]) / 3;
                default: ;
            endcase
            send_query(v[0], v[1], v[2], v[3], v[4], v[5],
                       v[6], v[7], v[8], v[9], v[10], v[11]);
        end
    endtask

    task automatic test_pause_until_drained();
        test_random(200);
        wait_drained();
        test_random(50);
    endtask

    // ---------------- receiver and checking ----------------
    always @(negedge i_clk) begin
        if (stall_cnt == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_cnt = $urandom_range(20, 200);
        end else begin
            stall_cnt--;
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= 1'($urandom_range(0, 1));
            default: i_stall <= (stall_cnt % 16) < 5;
        endcase
    end

    always @(posedge i_clk) begin
        t_near_pt want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_near.size() == 0) begin
                $display("%0t: unexpected result beat", $time);
                errors++;
            end else begin
                want = pending_near.pop_front();
                if (o_near_x !== want.near_x || o_near_y !== want.near_y
                    || o_near_z !== want.near_z) begin
                    $display("%0t: near exp %h %h %h got %h %h %h", $time, want.near_x,
                             want.near_y, want.near_z, o_near_x, o_near_y, o_near_z);
                    errors++;
                end
                if (o_weight_a !== want.wa || o_weight_b !== want.wb
                    || o_weight_c !== want.wc) begin
                    $display("%0t: weights exp %h %h %h got %h %h %h", $time, want.wa,
                             want.wb, want.wc, o_weight_a, o_weight_b, o_weight_c);
                    errors++;
                end
                if (o_distance_squared !== want.dsq) begin
                    $display("%0t: dist exp %h got %h", $time, want.dsq,
                             o_distance_squared);
                    errors++;
                end
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_pause_until_drained();
        test_random(1480);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_near.size() == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
